/* design/image_header_dimension_sniffer_macros.svh */
// ---------------------------------------------------------------------------
// Image header dimension sniffer - assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef IMAGE_HEADER_DIMENSION_SNIFFER_MACROS_SVH
`define IMAGE_HEADER_DIMENSION_SNIFFER_MACROS_SVH

// same-cycle implication, disabled during reset
`define IHDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ihds assertion failed");

// next-cycle implication, disabled during reset
`define IHDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ihds assertion failed");

`endif

/* design/ihds_pkg.sv */
// ---------------------------------------------------------------------------
// ihds_pkg
// Types, format codes and signature tables for the image header sniffer.
// ---------------------------------------------------------------------------
package ihds_pkg;

    localparam int HEADER_BYTES_DEF = 4096;

    // one input transfer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // one result transfer
    typedef struct packed {
        logic [2:0]  format_code;
        logic [31:0] image_width;
        logic [31:0] image_height;
    } out_item_t;

    // format codes
    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_PNG  = 3'd1;
    localparam logic [2:0] FMT_GIF  = 3'd2;
    localparam logic [2:0] FMT_BMP  = 3'd3;
    localparam logic [2:0] FMT_JPEG = 3'd4;
    localparam logic [2:0] FMT_WEBP = 3'd5;

    // candidate bit positions in the signature match vector
    localparam int SIG_PNG   = 0;
    localparam int SIG_GIF87 = 1;
    localparam int SIG_GIF89 = 2;
    localparam int SIG_BMP   = 3;
    localparam int SIG_JPEG  = 4;
    localparam int SIG_WEBP  = 5;

    // WebP chunk variants
    localparam logic [1:0] WEBP_NONE = 2'd0;
    localparam logic [1:0] WEBP_VP8X = 2'd1;
    localparam logic [1:0] WEBP_VP8L = 2'd2;
    localparam logic [1:0] WEBP_VP8  = 2'd3;

    // JPEG markers
    localparam logic [7:0] JPEG_FILL      = 8'hFF;
    localparam logic [7:0] JPEG_SOF_FIRST = 8'hC0;
    localparam logic [7:0] JPEG_SOF_LAST  = 8'hCF;
    localparam logic [7:0] JPEG_DHT       = 8'hC4;
    localparam logic [7:0] JPEG_JPG       = 8'hC8;
    localparam logic [7:0] JPEG_DAC       = 8'hCC;

    localparam logic [31:0] VP8_DIM_MASK = 32'h0000_3FFF;

    // JPEG segment walk phases
    typedef enum logic [2:0] {
        JP_PREFIX,
        JP_MARKER,
        JP_LEN_HI,
        JP_LEN_LO,
        JP_FRAME,
        JP_STOP
    } jpeg_phase_t;

    // signature tables
    localparam logic [7:0] PNG_SIG [0:7] =
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [7:0] GIF87_SIG [0:7] =
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00};
    localparam logic [7:0] GIF89_SIG [0:7] =
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00};
    localparam logic [7:0] BMP_SIG  [0:1] = '{8'h42, 8'h4D};
    localparam logic [7:0] JPEG_SIG [0:1] = '{8'hFF, 8'hD8};
    localparam logic [7:0] RIFF_SIG [0:3] = '{8'h52, 8'h49, 8'h46, 8'h46};
    localparam logic [7:0] WEBP_SIG [0:3] = '{8'h57, 8'h45, 8'h42, 8'h50};
    localparam logic [7:0] VP8_TAG  [0:3] = '{8'h56, 8'h50, 8'h38, 8'h00};

    localparam logic [7:0] CHR_X     = 8'h58;
    localparam logic [7:0] CHR_L     = 8'h4C;
    localparam logic [7:0] CHR_SPACE = 8'h20;

endpackage

/* design/ihds_parse.sv */
// ---------------------------------------------------------------------------
// ihds_parse
// Per-file parse state: signature match, field capture and JPEG walk.
// Builds the result from the state as it stands after the current byte.
// ---------------------------------------------------------------------------
module ihds_parse #(
    parameter int HEADER_BYTES = ihds_pkg::HEADER_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  ihds_pkg::in_item_t   in_item,
    output ihds_pkg::out_item_t  result
);
    import ihds_pkg::*;

    localparam int POS_W = $clog2(HEADER_BYTES + 1);
    localparam int SEG_W = ((POS_W > 16) ? POS_W : 16) + 1;

    // OR one byte into a little-endian lane
    function automatic logic [31:0] lane_or(input logic [31:0] word, input logic [7:0] b,
                                            input logic [1:0] lane);
        lane_or = word | ({24'd0, b} << {lane, 3'b000});
    endfunction

    logic [POS_W-1:0] pos_reg, pos_next, pos_upd;
    logic [5:0]       match_reg, match_next, match_upd;
    logic [31:0]      wcap_reg, wcap_next, wcap_upd;
    logic [31:0]      hcap_reg, hcap_next, hcap_upd;
    logic [1:0]       fc_reg, fc_next, fc_upd;
    jpeg_phase_t      jp_reg, jp_next, jp_upd;
    logic [SEG_W-1:0] seg_reg, seg_next, seg_upd;
    logic [7:0]       marker_reg, marker_next, marker_upd;
    logic [15:0]      jlen_reg, jlen_next, jlen_upd;
    logic [1:0]       kind_reg, kind_next, kind_upd;
    logic             tag_ok_reg, tag_ok_next, tag_ok_upd;

    logic [7:0]       b;
    logic             in_window;
    logic             p_lo;
    logic [4:0]       p5;
    logic [SEG_W-1:0] p_ext;
    logic [SEG_W-1:0] seg_off;
    logic [15:0]      len_full;

    assign b         = in_item.data_byte;
    assign in_window = pos_reg < POS_W'(HEADER_BYTES);
    assign p_lo      = pos_reg < POS_W'(32);
    assign p5        = pos_reg[4:0];
    assign p_ext     = SEG_W'(pos_reg);
    assign seg_off   = p_ext - seg_reg;
    assign len_full  = {jlen_reg[15:8], b};

    // state after taking the current byte
    always_comb begin
        pos_upd    = pos_reg;
        match_upd  = match_reg;
        wcap_upd   = wcap_reg;
        hcap_upd   = hcap_reg;
        fc_upd     = fc_reg;
        jp_upd     = jp_reg;
        seg_upd    = seg_reg;
        marker_upd = marker_reg;
        jlen_upd   = jlen_reg;
        kind_upd   = kind_reg;
        tag_ok_upd = tag_ok_reg;

        if (in_window) begin
            pos_upd = pos_reg + POS_W'(1);

            // signature elimination
            if (pos_reg < POS_W'(8) && b != PNG_SIG[pos_reg[2:0]])
                match_upd[SIG_PNG] = 1'b0;
            if (pos_reg < POS_W'(6) && b != GIF87_SIG[pos_reg[2:0]])
                match_upd[SIG_GIF87] = 1'b0;
            if (pos_reg < POS_W'(6) && b != GIF89_SIG[pos_reg[2:0]])
                match_upd[SIG_GIF89] = 1'b0;
            if (pos_reg < POS_W'(2) && b != BMP_SIG[pos_reg[0]])
                match_upd[SIG_BMP] = 1'b0;
            if (pos_reg < POS_W'(2) && b != JPEG_SIG[pos_reg[0]])
                match_upd[SIG_JPEG] = 1'b0;
            if (pos_reg < POS_W'(4) && b != RIFF_SIG[pos_reg[1:0]])
                match_upd[SIG_WEBP] = 1'b0;
            if (pos_reg >= POS_W'(8) && pos_reg < POS_W'(12) && b != WEBP_SIG[pos_reg[1:0]])
                match_upd[SIG_WEBP] = 1'b0;

            // field capture, first surviving candidate wins
            if (match_upd[SIG_PNG]) begin
                if (p_lo) begin
                    case (p5)
                        5'd16, 5'd17, 5'd18, 5'd19: wcap_upd = {wcap_reg[23:0], b};
                        5'd20, 5'd21, 5'd22, 5'd23: hcap_upd = {hcap_reg[23:0], b};
                        default: ;
                    endcase
                    if (p5 == 5'd19) fc_upd[0] = 1'b1;
                    if (p5 == 5'd23) fc_upd[1] = 1'b1;
                end
            end else if (match_upd[SIG_GIF87] || match_upd[SIG_GIF89]) begin
                if (p_lo) begin
                    case (p5)
                        5'd6, 5'd7: wcap_upd = lane_or(wcap_reg, b, 2'(p5 - 5'd6));
                        5'd8, 5'd9: hcap_upd = lane_or(hcap_reg, b, 2'(p5 - 5'd8));
                        default: ;
                    endcase
                    if (p5 == 5'd7) fc_upd[0] = 1'b1;
                    if (p5 == 5'd9) fc_upd[1] = 1'b1;
                end
            end else if (match_upd[SIG_BMP]) begin
                if (p_lo) begin
                    case (p5)
                        5'd18, 5'd19, 5'd20, 5'd21:
                            wcap_upd = lane_or(wcap_reg, b, 2'(p5 - 5'd18));
                        5'd22, 5'd23, 5'd24, 5'd25:
                            hcap_upd = lane_or(hcap_reg, b, 2'(p5 - 5'd22));
                        default: ;
                    endcase
                    if (p5 == 5'd21) fc_upd[0] = 1'b1;
                    if (p5 == 5'd25) fc_upd[1] = 1'b1;
                end
            end else if (match_upd[SIG_JPEG]) begin
                // segment walk
                case (jp_reg)
                    JP_PREFIX: begin
                        if (p_ext == seg_reg)
                            jp_upd = (b == JPEG_FILL) ? JP_MARKER : JP_STOP;
                    end
                    JP_MARKER: begin
                        if (b == JPEG_FILL) begin
                            seg_upd = p_ext;
                        end else begin
                            marker_upd = b;
                            jp_upd     = JP_LEN_HI;
                        end
                    end
                    JP_LEN_HI: begin
                        jlen_upd = {b, 8'h00};
                        jp_upd   = JP_LEN_LO;
                    end
                    JP_LEN_LO: begin
                        jlen_upd = len_full;
                        if (len_full < 16'd2) begin
                            jp_upd = JP_STOP;
                        end else if ((marker_reg inside {[JPEG_SOF_FIRST:JPEG_SOF_LAST]}) &&
                                     !(marker_reg inside {JPEG_DHT, JPEG_JPG, JPEG_DAC})) begin
                            jp_upd = JP_FRAME;
                        end else begin
                            seg_upd = seg_reg + SEG_W'(len_full) + SEG_W'(2);
                            jp_upd  = JP_PREFIX;
                        end
                    end
                    JP_FRAME: begin
                        if (seg_off == SEG_W'(5)) begin
                            hcap_upd = {16'd0, b, 8'h00};
                        end else if (seg_off == SEG_W'(6)) begin
                            hcap_upd  = hcap_reg | {24'd0, b};
                            fc_upd[1] = 1'b1;
                        end else if (seg_off == SEG_W'(7)) begin
                            wcap_upd = {16'd0, b, 8'h00};
                        end else if (seg_off == SEG_W'(8)) begin
                            wcap_upd  = wcap_reg | {24'd0, b};
                            fc_upd[0] = 1'b1;
                            jp_upd    = JP_STOP;
                        end
                    end
                    default: ;
                endcase
            end else if (match_upd[SIG_WEBP]) begin
                if (p_lo) begin
                    if (p5 >= 5'd12 && p5 <= 5'd14) begin
                        if (b != VP8_TAG[2'(p5 - 5'd12)])
                            tag_ok_upd = 1'b0;
                    end else if (p5 == 5'd15) begin
                        if (tag_ok_reg) begin
                            if (b == CHR_X)
                                kind_upd = WEBP_VP8X;
                            else if (b == CHR_L)
                                kind_upd = WEBP_VP8L;
                            else if (b == CHR_SPACE)
                                kind_upd = WEBP_VP8;
                        end
                    end else begin
                        case (kind_reg)
                            WEBP_VP8X: begin
                                if (p5 >= 5'd24 && p5 <= 5'd26)
                                    wcap_upd = lane_or(wcap_reg, b, 2'(p5 - 5'd24));
                                else if (p5 >= 5'd27 && p5 <= 5'd29)
                                    hcap_upd = lane_or(hcap_reg, b, 2'(p5 - 5'd27));
                                if (p5 == 5'd29) fc_upd = 2'b11;
                            end
                            WEBP_VP8L: begin
                                if (p5 >= 5'd21 && p5 <= 5'd24)
                                    wcap_upd = lane_or(wcap_reg, b, 2'(p5 - 5'd21));
                                if (p5 == 5'd24) fc_upd = 2'b11;
                            end
                            WEBP_VP8: begin
                                if (p5 >= 5'd26 && p5 <= 5'd27)
                                    wcap_upd = lane_or(wcap_reg, b, 2'(p5 - 5'd26));
                                else if (p5 >= 5'd28 && p5 <= 5'd29)
                                    hcap_upd = lane_or(hcap_reg, b, 2'(p5 - 5'd28));
                                if (p5 == 5'd29) fc_upd = 2'b11;
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
    end

    // next state: end of file returns everything to its reset values
    always_comb begin
        pos_next    = pos_reg;
        match_next  = match_reg;
        wcap_next   = wcap_reg;
        hcap_next   = hcap_reg;
        fc_next     = fc_reg;
        jp_next     = jp_reg;
        seg_next    = seg_reg;
        marker_next = marker_reg;
        jlen_next   = jlen_reg;
        kind_next   = kind_reg;
        tag_ok_next = tag_ok_reg;
        if (accept) begin
            if (in_item.last_byte) begin
                pos_next    = '0;
                match_next  = '1;
                wcap_next   = '0;
                hcap_next   = '0;
                fc_next     = '0;
                jp_next     = JP_PREFIX;
                seg_next    = SEG_W'(2);
                marker_next = '0;
                jlen_next   = '0;
                kind_next   = WEBP_NONE;
                tag_ok_next = 1'b1;
            end else begin
                pos_next    = pos_upd;
                match_next  = match_upd;
                wcap_next   = wcap_upd;
                hcap_next   = hcap_upd;
                fc_next     = fc_upd;
                jp_next     = jp_upd;
                seg_next    = seg_upd;
                marker_next = marker_upd;
                jlen_next   = jlen_upd;
                kind_next   = kind_upd;
                tag_ok_next = tag_ok_upd;
            end
        end
    end

    // walk phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jp_reg <= JP_PREFIX;
        end else begin
            jp_reg <= jp_next;
        end
    end

    // remaining parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            match_reg  <= '1;
            wcap_reg   <= '0;
            hcap_reg   <= '0;
            fc_reg     <= '0;
            seg_reg    <= SEG_W'(2);
            marker_reg <= '0;
            jlen_reg   <= '0;
            kind_reg   <= WEBP_NONE;
            tag_ok_reg <= 1'b1;
        end else begin
            pos_reg    <= pos_next;
            match_reg  <= match_next;
            wcap_reg   <= wcap_next;
            hcap_reg   <= hcap_next;
            fc_reg     <= fc_next;
            seg_reg    <= seg_next;
            marker_reg <= marker_next;
            jlen_reg   <= jlen_next;
            kind_reg   <= kind_next;
            tag_ok_reg <= tag_ok_next;
        end
    end

    // result from the state after this byte
    always_comb begin
        logic [31:0] w;
        logic [31:0] h;
        logic [2:0]  fmt;
        w   = fc_upd[0] ? wcap_upd : 32'd0;
        h   = fc_upd[1] ? hcap_upd : 32'd0;
        fmt = FMT_NONE;
        if (match_upd[SIG_PNG] && pos_upd >= POS_W'(8)) begin
            fmt = FMT_PNG;
        end else if ((match_upd[SIG_GIF87] || match_upd[SIG_GIF89]) &&
                     pos_upd >= POS_W'(6)) begin
            fmt = FMT_GIF;
        end else if (match_upd[SIG_BMP] && pos_upd >= POS_W'(2)) begin
            fmt = FMT_BMP;
            if (h[31])
                h = 32'd0 - h;
        end else if (match_upd[SIG_JPEG] && pos_upd >= POS_W'(2)) begin
            fmt = FMT_JPEG;
        end else if (match_upd[SIG_WEBP] && pos_upd >= POS_W'(12)) begin
            fmt = FMT_WEBP;
            if (fc_upd != 2'b11 || kind_upd == WEBP_NONE) begin
                w = 32'd0;
                h = 32'd0;
            end else if (kind_upd == WEBP_VP8X) begin
                w = wcap_upd + 32'd1;
                h = hcap_upd + 32'd1;
            end else if (kind_upd == WEBP_VP8L) begin
                w = (wcap_upd & VP8_DIM_MASK) + 32'd1;
                h = ((wcap_upd >> 14) & VP8_DIM_MASK) + 32'd1;
            end else begin
                w = wcap_upd & VP8_DIM_MASK;
                h = hcap_upd & VP8_DIM_MASK;
            end
        end
        if (fmt == FMT_NONE) begin
            w = 32'd0;
            h = 32'd0;
        end
        result.format_code  = fmt;
        result.image_width  = w;
        result.image_height = h;
    end

endmodule

/* design/ihds_out.sv */
// ---------------------------------------------------------------------------
// ihds_out
// Result register with valid/ready handshake toward the receiver.
// ---------------------------------------------------------------------------
module ihds_out (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  ihds_pkg::out_item_t  result,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ihds_pkg::out_item_t  m_data
);
    import ihds_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t data_reg, data_next;

    // register is free when empty or draining this cycle
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (m_ready)
            valid_next = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* design/image_header_dimension_sniffer.sv */
// ---------------------------------------------------------------------------
// image_header_dimension_sniffer
// Streams a file's leading bytes and reports image format and dimensions.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one file byte per transfer, from offset zero; last_byte
//   marks the final byte and ends the file. Bytes beyond HEADER_BYTES are
//   taken but ignored, apart from last_byte.
//   m_ channel: one result per file (format code, width, height), issued
//   for the transfer that carries last_byte. Other bytes give no result.
//   Latency: the result is valid on m_ the cycle after the last byte is
//   taken. Throughput: one byte per cycle while s_ready is high, as the parse
//   state updates on every accepted byte; consecutive files may follow back to back.
//   Stall: while a result waits on m_ready low, s_ready drops; it stays
//   high whenever the result register is empty or draining.
//   Reset: aresetn (synchronous, active low) clears the parse state to the
//   start of a file and empties the result register.
// ---------------------------------------------------------------------------
module image_header_dimension_sniffer #(
    parameter int HEADER_BYTES = ihds_pkg::HEADER_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ihds_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ihds_pkg::out_item_t  m_data
);
    import ihds_pkg::*;

    logic      accept;
    logic      free;
    out_item_t result;

    assign s_ready = free;
    assign accept  = s_valid && free;

    ihds_parse #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_item (s_data),
        .result  (result)
    );

    ihds_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept && s_data.last_byte),
        .result  (result),
        .free    (free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* design/ihds_checker.sv */
// ---------------------------------------------------------------------------
// ihds_checker
// Port-level checks for the image header sniffer, bound to the top level.
// ---------------------------------------------------------------------------
`include "image_header_dimension_sniffer_macros.svh"

module ihds_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input ihds_pkg::in_item_t   s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input ihds_pkg::out_item_t  m_data
);
    import ihds_pkg::*;

    logic out_stall;
    logic in_last_xfer;
    logic dims_ok;

    assign out_stall    = m_valid && !m_ready;
    assign in_last_xfer = s_valid && s_ready && s_data.last_byte;
    assign dims_ok      = (m_data.format_code <= FMT_WEBP) &&
                          (m_data.format_code != FMT_NONE ||
                           (m_data.image_width == 32'd0 && m_data.image_height == 32'd0));

    // a stalled result holds
    `IHDS_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(m_data))

    // input never stalls while the result register is empty
    `IHDS_ASSERT_IMPL(a_no_idle_stall, aclk, aresetn, !m_valid, s_ready)

    // a new result only follows a transfer carrying last_byte
    `IHDS_ASSERT_IMPL(a_result_cause, aclk, aresetn, $rose(m_valid), $past(in_last_xfer))

    // valid format codes, and no dimensions for an unrecognized file
    `IHDS_ASSERT_IMPL(a_format_dims, aclk, aresetn, m_valid, dims_ok)

endmodule

bind image_header_dimension_sniffer ihds_checker u_checker (.*);

/* tb/tb_image_header_dimension_sniffer.sv */
// ---------------------------------------------------------------------------
// tb_image_header_dimension_sniffer
// Streams synthetic file headers (PNG, GIF, BMP, JPEG, WebP and noise) into
// the sniffer one byte per transfer, predicts format and dimensions with a
// local byte-accurate model, and checks every result transfer in order.
// ---------------------------------------------------------------------------
module tb_image_header_dimension_sniffer;
    import ihds_pkg::*;

    localparam int WINDOW      = 4096;
    localparam int CYCLE_LIMIT = 400000;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;

    image_header_dimension_sniffer #(
        .HEADER_BYTES (WINDOW)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // bookkeeping
    out_item_t   expected_dims [$];
    logic [7:0]  file_buf [$];
    int          mismatches   = 0;
    int          results_seen = 0;
    int          files_sent   = 0;
    int          bytes_sent   = 0;
    int          cycle_count  = 0;
    logic        steady       = 1'b0;

    // local copy of the parser state
    logic [12:0]  sn_pos;
    logic [5:0]   sn_cand;
    logic [31:0]  sn_w;
    logic [31:0]  sn_h;
    logic [1:0]   sn_done;
    jpeg_phase_t  jp_phase;
    logic [16:0]  jp_seg;
    logic [7:0]   jp_mark;
    logic [15:0]  jp_len;
    logic [1:0]   wp_kind;
    logic         wp_tag_ok;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [31:0] lane(input logic [7:0] b, input int k);
        return 32'(b) << (8 * k);
    endfunction

    function automatic logic is_frame_marker(input logic [7:0] m);
        return m >= JPEG_SOF_FIRST && m <= JPEG_SOF_LAST &&
               m != JPEG_DHT && m != JPEG_JPG && m != JPEG_DAC;
    endfunction

    task clear_sniff();
        sn_pos    = '0;
        sn_cand   = '1;
        sn_w      = '0;
        sn_h      = '0;
        sn_done   = '0;
        jp_phase  = JP_PREFIX;
        jp_seg    = 17'd2;
        jp_mark   = '0;
        jp_len    = '0;
        wp_kind   = WEBP_NONE;
        wp_tag_ok = 1'b1;
    endtask

    // one byte inside the window, at offset sn_pos
    task sniff_accept(input logic [7:0] b);
        logic [12:0] p;
        logic [16:0] off;
        p = sn_pos;

        // signature elimination
        if (p < 8 && b != PNG_SIG[p[2:0]]) sn_cand[SIG_PNG] = 1'b0;
        if (p < 6 && b != GIF87_SIG[p[2:0]]) sn_cand[SIG_GIF87] = 1'b0;
        if (p < 6 && b != GIF89_SIG[p[2:0]]) sn_cand[SIG_GIF89] = 1'b0;
        if (p < 2 && b != BMP_SIG[p[0]]) sn_cand[SIG_BMP] = 1'b0;
        if (p < 2 && b != JPEG_SIG[p[0]]) sn_cand[SIG_JPEG] = 1'b0;
        if (p < 4 && b != RIFF_SIG[p[1:0]]) sn_cand[SIG_WEBP] = 1'b0;
        if (p >= 8 && p < 12 && b != WEBP_SIG[p[1:0]]) sn_cand[SIG_WEBP] = 1'b0;

        if (sn_cand[SIG_PNG]) begin
            // big-endian fields at 16 and 20
            if (p >= 16 && p <= 19) sn_w = {sn_w[23:0], b};
            else if (p >= 20 && p <= 23) sn_h = {sn_h[23:0], b};
            if (p == 19) sn_done[0] = 1'b1;
            if (p == 23) sn_done[1] = 1'b1;
        end else if (sn_cand[SIG_GIF87] || sn_cand[SIG_GIF89]) begin
            if (p >= 6 && p <= 7) sn_w = sn_w | lane(b, p - 6);
            else if (p >= 8 && p <= 9) sn_h = sn_h | lane(b, p - 8);
            if (p == 7) sn_done[0] = 1'b1;
            if (p == 9) sn_done[1] = 1'b1;
        end else if (sn_cand[SIG_BMP]) begin
            if (p >= 18 && p <= 21) sn_w = sn_w | lane(b, p - 18);
            else if (p >= 22 && p <= 25) sn_h = sn_h | lane(b, p - 22);
            if (p == 21) sn_done[0] = 1'b1;
            if (p == 25) sn_done[1] = 1'b1;
        end else if (sn_cand[SIG_JPEG]) begin
            // segment chain walk
            case (jp_phase)
                JP_PREFIX: begin
                    if (17'(p) == jp_seg) begin
                        if (b == JPEG_FILL) jp_phase = JP_MARKER;
                        else jp_phase = JP_STOP;
                    end
                end
                JP_MARKER: begin
                    if (b == JPEG_FILL) begin
                        jp_seg = 17'(p);
                    end else begin
                        jp_mark  = b;
                        jp_phase = JP_LEN_HI;
                    end
                end
                JP_LEN_HI: begin
                    jp_len   = {b, 8'h00};
                    jp_phase = JP_LEN_LO;
                end
                JP_LEN_LO: begin
                    jp_len = {jp_len[15:8], b};
                    if (jp_len < 16'd2) begin
                        jp_phase = JP_STOP;
                    end else if (is_frame_marker(jp_mark)) begin
                        jp_phase = JP_FRAME;
                    end else begin
                        jp_seg   = jp_seg + 17'd2 + 17'(jp_len);
                        jp_phase = JP_PREFIX;
                    end
                end
                JP_FRAME: begin
                    off = 17'(p) - jp_seg;
                    case (off)
                        17'd5: sn_h = {16'h0, b, 8'h00};
                        17'd6: begin
                            sn_h       = sn_h | 32'(b);
                            sn_done[1] = 1'b1;
                        end
                        17'd7: sn_w = {16'h0, b, 8'h00};
                        17'd8: begin
                            sn_w       = sn_w | 32'(b);
                            sn_done[0] = 1'b1;
                            jp_phase   = JP_STOP;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end else if (sn_cand[SIG_WEBP]) begin
            // chunk tag, then variant fields
            if (p >= 12 && p <= 14) begin
                if (b != VP8_TAG[2'(p - 12)]) wp_tag_ok = 1'b0;
            end else if (p == 15) begin
                if (wp_tag_ok) begin
                    if (b == CHR_X) wp_kind = WEBP_VP8X;
                    else if (b == CHR_L) wp_kind = WEBP_VP8L;
                    else if (b == CHR_SPACE) wp_kind = WEBP_VP8;
                end
            end else begin
                case (wp_kind)
                    WEBP_VP8X: begin
                        if (p >= 24 && p <= 26) sn_w = sn_w | lane(b, p - 24);
                        else if (p >= 27 && p <= 29) sn_h = sn_h | lane(b, p - 27);
                        if (p == 29) sn_done = 2'b11;
                    end
                    WEBP_VP8L: begin
                        if (p >= 21 && p <= 24) sn_w = sn_w | lane(b, p - 21);
                        if (p == 24) sn_done = 2'b11;
                    end
                    WEBP_VP8: begin
                        if (p >= 26 && p <= 27) sn_w = sn_w | lane(b, p - 26);
                        else if (p >= 28 && p <= 29) sn_h = sn_h | lane(b, p - 28);
                        if (p == 29) sn_done = 2'b11;
                    end
                    default: ;
                endcase
            end
        end
    endtask

    // one accepted transfer; a result comes out on the last byte only
    task predict_dims(input in_item_t item, output logic emitted, output out_item_t res);
        logic [2:0]  fmt;
        logic [31:0] w;
        logic [31:0] h;
        emitted = 1'b0;
        res     = '0;
        if (sn_pos < WINDOW) begin
            sniff_accept(item.data_byte);
            sn_pos = sn_pos + 13'd1;
        end
        if (item.last_byte) begin
            w   = sn_done[0] ? sn_w : 32'd0;
            h   = sn_done[1] ? sn_h : 32'd0;
            fmt = FMT_NONE;
            if (sn_cand[SIG_PNG] && sn_pos >= 8) begin
                fmt = FMT_PNG;
            end else if ((sn_cand[SIG_GIF87] || sn_cand[SIG_GIF89]) && sn_pos >= 6) begin
                fmt = FMT_GIF;
            end else if (sn_cand[SIG_BMP] && sn_pos >= 2) begin
                fmt = FMT_BMP;
                if (h[31]) h = 32'd0 - h;
            end else if (sn_cand[SIG_JPEG] && sn_pos >= 2) begin
                fmt = FMT_JPEG;
            end else if (sn_cand[SIG_WEBP] && sn_pos >= 12) begin
                fmt = FMT_WEBP;
                if (sn_done != 2'b11 || wp_kind == WEBP_NONE) begin
                    w = '0;
                    h = '0;
                end else begin
                    case (wp_kind)
                        WEBP_VP8X: begin
                            w = sn_w + 32'd1;
                            h = sn_h + 32'd1;
                        end
                        WEBP_VP8L: begin
                            w = (sn_w & VP8_DIM_MASK) + 32'd1;
                            h = ((sn_w >> 14) & VP8_DIM_MASK) + 32'd1;
                        end
                        default: begin
                            w = sn_w & VP8_DIM_MASK;
                            h = sn_h & VP8_DIM_MASK;
                        end
                    endcase
                end
            end
            if (fmt == FMT_NONE) begin
                w = '0;
                h = '0;
            end
            res.format_code  = fmt;
            res.image_width  = w;
            res.image_height = h;
            emitted = 1'b1;
            clear_sniff();
        end
    endtask

    initial clear_sniff();

    // ------------------------------------------------------------------
    // Monitor: predict on input transfers, check result transfers
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        logic      fresh;
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_dims.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: fmt=%0d w=%h h=%h",
                                 m_data.format_code, m_data.image_width,
                                 m_data.image_height);
                end else begin
                    want = expected_dims.pop_front();
                    if (m_data.format_code !== want.format_code ||
                        m_data.image_width !== want.image_width ||
                        m_data.image_height !== want.image_height) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected fmt=%0d w=%h h=%h, got fmt=%0d w=%h h=%h",
                                     want.format_code, want.image_width, want.image_height,
                                     m_data.format_code, m_data.image_width,
                                     m_data.image_height);
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_dims(s_data, fresh, want);
                if (fresh) expected_dims.push_back(want);
            end
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 20);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_dims.size());
            $display("tb_image_header_dimension_sniffer: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Transfer helpers
    // ------------------------------------------------------------------
    task send_byte(input logic [7:0] b, input logic l);
        if (!steady && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= in_item_t'{data_byte: b, last_byte: l};
        do @(posedge aclk); while (!s_ready);
    endtask

    task send_file();
        for (int i = 0; i < file_buf.size(); i++)
            send_byte(file_buf[i], i == file_buf.size() - 1);
        bytes_sent += file_buf.size();
        files_sent++;
        file_buf.delete();
    endtask

    // sender holds off until every result has drained
    task settle_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_dims.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    task put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_buf.push_back(v[8*i +: 8]);
    endtask

    task put_be(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) file_buf.push_back(v[8*i +: 8]);
    endtask

    task put_rand(input int n);
        repeat (n) file_buf.push_back(8'($urandom));
    endtask

    task trim_file(input int n);
        while (file_buf.size() > n) void'(file_buf.pop_back());
    endtask

    function automatic logic [31:0] rand_dim();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task build_png(input logic [31:0] w, input logic [31:0] h);
        for (int i = 0; i < 8; i++) file_buf.push_back(PNG_SIG[i]);
        put_be(32'd13, 4);
        put_rand(4);
        put_be(w, 4);
        put_be(h, 4);
        put_rand($urandom_range(0, 5));
    endtask

    task build_gif(input logic v89, input logic [15:0] w, input logic [15:0] h);
        for (int i = 0; i < 6; i++) file_buf.push_back(v89 ? GIF89_SIG[i] : GIF87_SIG[i]);
        put_le(32'(w), 2);
        put_le(32'(h), 2);
        put_rand($urandom_range(0, 4));
    endtask

    task build_bmp(input logic [31:0] w, input logic [31:0] h);
        file_buf.push_back(BMP_SIG[0]);
        file_buf.push_back(BMP_SIG[1]);
        put_rand(16);
        put_le(w, 4);
        put_le(h, 4);
        put_rand($urandom_range(0, 4));
    endtask

    // RIFF/WEBP container with a VP8? chunk tag ending in tag_chr
    task build_webp(input logic [7:0] tag_chr, input logic [31:0] a, input logic [31:0] c);
        for (int i = 0; i < 4; i++) file_buf.push_back(RIFF_SIG[i]);
        put_rand(4);
        for (int i = 0; i < 4; i++) file_buf.push_back(WEBP_SIG[i]);
        for (int i = 0; i < 3; i++) file_buf.push_back(VP8_TAG[i]);
        file_buf.push_back(tag_chr);
        if (tag_chr == CHR_X) begin
            put_rand(8);
            put_le(a, 3);
            put_le(c, 3);
        end else if (tag_chr == CHR_L) begin
            put_rand(5);
            put_le(a, 4);
        end else begin
            put_rand(10);
            put_le(a, 2);
            put_le(c, 2);
        end
        put_rand($urandom_range(0, 4));
    endtask

    task put_jpeg_sig();
        file_buf.push_back(JPEG_SIG[0]);
        file_buf.push_back(JPEG_SIG[1]);
    endtask

    // plain segment: prefix, fill bytes, marker, length, body
    task put_jpeg_seg(input logic [7:0] marker, input int len, input int nfill);
        file_buf.push_back(JPEG_FILL);
        repeat (nfill) file_buf.push_back(JPEG_FILL);
        file_buf.push_back(marker);
        put_be(32'(len), 2);
        if (len > 2) put_rand(len - 2);
    endtask

    // frame header: length 17, precision, height, width, then some body
    task put_sof(input logic [7:0] marker, input logic [15:0] w, input logic [15:0] h,
                 input int nfill);
        file_buf.push_back(JPEG_FILL);
        repeat (nfill) file_buf.push_back(JPEG_FILL);
        file_buf.push_back(marker);
        put_be(32'd17, 2);
        file_buf.push_back(8'd8);
        put_be(32'(h), 2);
        put_be(32'(w), 2);
        put_rand(3);
    endtask

    function automatic logic [7:0] pick_plain_marker();
        case ($urandom_range(0, 7))
            0: return 8'hE0 | 8'($urandom_range(0, 15));
            1: return 8'hDB;
            2: return JPEG_DHT;
            3: return JPEG_JPG;
            4: return JPEG_DAC;
            5: return 8'hFE;
            6: return 8'hDD;
            default: return 8'($urandom_range(1, 8'hBF));
        endcase
    endfunction

    function automatic logic [7:0] pick_sof_marker();
        logic [7:0] m;
        m = JPEG_SOF_FIRST | 8'($urandom_range(0, 15));
        if (m == JPEG_DHT || m == JPEG_JPG || m == JPEG_DAC) m = JPEG_SOF_FIRST;
        return m;
    endfunction

    // well-formed header of a random format with random content
    task build_random_file();
        logic [7:0] tag_chr;
        case ($urandom_range(0, 4))
            0: build_png(rand_dim(), rand_dim());
            1: build_gif(1'($urandom_range(0, 1)), 16'(rand_dim()), 16'(rand_dim()));
            2: build_bmp(rand_dim(), rand_dim());
            3: begin
                put_jpeg_sig();
                repeat ($urandom_range(0, 3))
                    put_jpeg_seg(pick_plain_marker(), $urandom_range(2, 10),
                                 $urandom_range(0, 2));
                put_sof(pick_sof_marker(), 16'(rand_dim()), 16'(rand_dim()),
                        $urandom_range(0, 2));
            end
            default: begin
                case ($urandom_range(0, 6))
                    0, 1: tag_chr = CHR_X;
                    2, 3: tag_chr = CHR_L;
                    4, 5: tag_chr = CHR_SPACE;
                    default: tag_chr = 8'($urandom);
                endcase
                build_webp(tag_chr, rand_dim(), rand_dim());
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task test_png_headers();
        build_png(32'hFFFF_FFFF, 32'h0000_0000);
        send_file();
        // height bytes cut short
        build_png(32'h0000_0001, 32'h8000_0000);
        trim_file(22);
        send_file();
        // signature one byte short
        build_png(32'd1, 32'd1);
        trim_file(7);
        send_file();
        settle_results();
    endtask

    task test_gif_headers();
        build_gif(1'b0, 16'hFFFF, 16'h0001);
        send_file();
        build_gif(1'b1, 16'h0000, 16'hFFFF);
        send_file();
        // width complete, height half there
        build_gif(1'b1, 16'h1234, 16'h5678);
        trim_file(9);
        send_file();
        build_gif(1'b0, 16'd10, 16'd10);
        trim_file(5);
        send_file();
        settle_results();
    endtask

    task test_bmp_headers();
        build_bmp(32'd1234, 32'hFFFF_FE20);
        send_file();
        // most negative height stays as is
        build_bmp(32'hFFFF_FFFF, 32'h8000_0000);
        send_file();
        build_bmp(32'd0, 32'h7FFF_FFFF);
        send_file();
        build_bmp(32'd640, 32'd480);
        trim_file(24);
        send_file();
        file_buf.push_back(BMP_SIG[0]);
        send_file();
        file_buf.push_back(BMP_SIG[0]);
        file_buf.push_back(BMP_SIG[1]);
        send_file();
        settle_results();
    endtask

    task test_jpeg_walk();
        // app segment, then fill bytes ahead of the frame header
        put_jpeg_sig();
        put_jpeg_seg(8'hE0, 16, 0);
        put_sof(JPEG_SOF_FIRST, 16'd1920, 16'd1080, 2);
        send_file();
        // markers in the frame range that are not frame headers
        put_jpeg_sig();
        put_jpeg_seg(JPEG_DHT, 5, 0);
        put_jpeg_seg(JPEG_JPG, 2, 1);
        put_jpeg_seg(JPEG_DAC, 4, 0);
        put_sof(8'hC2, 16'hFFFF, 16'hFFFF, 0);
        send_file();
        put_jpeg_sig();
        put_sof(JPEG_SOF_LAST, 16'h0001, 16'h0000, 0);
        send_file();
        // missing prefix stops the walk
        put_jpeg_sig();
        file_buf.push_back(8'h00);
        put_sof(JPEG_SOF_FIRST, 16'd8, 16'd8, 0);
        send_file();
        // segment length below two stops the walk
        put_jpeg_sig();
        put_jpeg_seg(8'hE0, 1, 0);
        put_sof(JPEG_SOF_FIRST, 16'd8, 16'd8, 0);
        send_file();
        put_jpeg_sig();
        put_jpeg_seg(8'hE1, 0, 0);
        send_file();
        // frame header ends after the height
        put_jpeg_sig();
        put_sof(8'hC1, 16'd300, 16'd200, 0);
        trim_file(9);
        send_file();
        settle_results();
    endtask

    task test_webp_chunks();
        build_webp(CHR_X, 32'h00FF_FFFF, 32'h0000_0000);
        send_file();
        build_webp(CHR_L, 32'hFFFF_FFFF, 32'd0);
        send_file();
        build_webp(CHR_L, 32'h0000_0000, 32'd0);
        send_file();
        build_webp(CHR_SPACE, 32'h0000_FFFF, 32'h0000_1234);
        send_file();
        // unknown chunk tags
        build_webp(8'h51, 32'd5, 32'd5);
        send_file();
        build_webp(CHR_X, 32'd5, 32'd5);
        file_buf[12] = 8'h41;
        send_file();
        // variant header short by one byte
        build_webp(CHR_X, 32'd99, 32'd99);
        trim_file(29);
        send_file();
        build_webp(CHR_L, 32'd99, 32'd0);
        trim_file(24);
        send_file();
        // container signature exactly complete, and one byte short
        build_webp(CHR_SPACE, 32'd1, 32'd1);
        trim_file(12);
        send_file();
        build_webp(CHR_SPACE, 32'd1, 32'd1);
        trim_file(11);
        send_file();
        settle_results();
    endtask

    task test_unrecognised();
        file_buf.push_back(8'h00);
        send_file();
        file_buf.push_back(8'hFF);
        send_file();
        file_buf.push_back(8'h00);
        put_rand(20);
        send_file();
        settle_results();
    endtask

    task test_back_to_back();
        steady <= 1'b1;
        repeat (4) begin
            build_random_file();
            send_file();
        end
        steady <= 1'b0;
        settle_results();
    endtask

    task test_random_files();
        int nbytes;
        int nfiles;
        nbytes = 0;
        nfiles = 0;
        while (nbytes < 60 || nfiles < 3) begin
            case ($urandom_range(0, 9))
                8: put_rand($urandom_range(1, 40));
                9: begin
                    // broken signature or header byte
                    build_random_file();
                    file_buf[$urandom_range(0, (file_buf.size() > 16) ? 15 :
                                               file_buf.size() - 1)] = 8'($urandom);
                end
                default: begin
                    build_random_file();
                    if ($urandom_range(0, 3) == 0)
                        trim_file($urandom_range(1, file_buf.size()));
                end
            endcase
            nbytes += file_buf.size();
            nfiles++;
            send_file();
        end
        settle_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_png_headers();
        test_gif_headers();
        test_bmp_headers();
        test_jpeg_walk();
        test_webp_chunks();
        test_unrecognised();
        test_back_to_back();
        test_random_files();

        $display("run covered %0d files, %0d bytes, %0d results checked, %0d mismatches",
                 files_sent, bytes_sent, results_seen, mismatches);
        $display("formats, truncated and corrupt headers, JPEG skips, WebP variants, bursts");
        if (expected_dims.size() != 0)
            $display("%0d expected results never arrived", expected_dims.size());
        if (mismatches == 0 && expected_dims.size() == 0) begin
            $display("tb_image_header_dimension_sniffer: clean");
        end else begin
            $display("tb_image_header_dimension_sniffer: errors");
        end
        $finish;
    end

endmodule
